// ----- rtl/upd_pkg.sv -----
package upd_pkg;

	localparam int unsigned MODE_W = 2;
	localparam int unsigned MAX_RES = 3;

	localparam logic [MODE_W-1:0] MODE_STRICT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LENIENT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DISCARD = 2'd2;

	localparam logic [1:0] PH_NONE    = 2'd0;
	localparam logic [1:0] PH_PERCENT = 2'd1;
	localparam logic [1:0] PH_HELD    = 2'd2;

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// One queue entry: all results caused by one input transaction.
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [1:0]              nres;
		logic                    bare;
		logic                    last;
		logic                    err;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- rtl/url_percent_decoder.sv -----
// URL percent decoder.
// The s_axis channel takes one encoded character per transaction; tlast marks
// the final character of a string. The m_axis channel gives decoded
// characters: tuser[0] says the byte is a character (0 for a bare end marker),
// tuser[1] flags a strict-mode decode error on the last result of a string.
// Every string ends with exactly one result that carries tlast.
// The cfg channel writes decode_mode (0 strict, 1 lenient, 2 discard) and is
// always ready; write it only between strings while the block is idle.
// Results are registered in the queue before they appear on m_axis.
// Throughput: one character per cycle while each character causes at most one
// result. The back end hands out one result per cycle, so a character that
// causes two or three results stays at the head of the queue until all are out;
// the QUEUE_DEPTH-entry queue between front and back absorbs such bursts.
// When m_axis stalls, results wait in the queue and s_axis_tready drops only
// once the queue is full.
// Reset clears the escape state, the error flag, the queue and the mode.
module url_percent_decoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [upd_pkg::MODE_W-1:0] cfg_data,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [7:0]                 s_axis_tdata,  // [7:0] in_byte
	input  logic                       s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [7:0]                 m_axis_tdata,  // [7:0] out_byte
	output logic [1:0]                 m_axis_tuser,  // [0] out_valid, [1] decode_error
	output logic                       m_axis_tlast
);

	logic [upd_pkg::MODE_W-1:0] mode_q;
	logic                       push;
	logic                       pop;
	upd_pkg::bundle_t           push_data;
	upd_pkg::bundle_t           head;
	upd_pkg::q_status_t         q_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= upd_pkg::MODE_STRICT;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	upd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	upd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_status   (q_status),
		.pop        (pop),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser),
		.out_tlast  (m_axis_tlast)
	);

endmodule

// ----- rtl/upd_front.sv -----
module upd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [upd_pkg::MODE_W-1:0]    mode,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    in_byte,
	input  logic                          in_last,
	input  upd_pkg::q_status_t            q_status,
	output logic                          push,
	output upd_pkg::bundle_t              push_data
);

	typedef struct packed {
		logic [1:0]                       phase;
		logic [7:0]                       held;
		logic                             err;
		logic [upd_pkg::MAX_RES-1:0][7:0] b;
		logic [1:0]                       cnt;
	} work_t;

	logic [1:0] phase_q;
	logic [7:0] held_q;
	logic       err_q;
	logic       accept;
	work_t      w_in;
	work_t      w_fed;
	work_t      w_done;

	// Bit 4 flags a valid hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	function automatic work_t put(input work_t w, input logic [7:0] ch);
		work_t r;
		r = w;
		if (r.cnt < 2'd3) begin
			r.b[r.cnt] = ch;
			r.cnt = r.cnt + 2'd1;
		end
		return r;
	endfunction

	function automatic work_t feed_base(input work_t w, input logic [7:0] c);
		work_t r;
		r = w;
		if (!r.err) begin
			r.phase = upd_pkg::PH_NONE;
			if (c == upd_pkg::CH_PLUS) r = put(r, upd_pkg::CH_SPACE);
			else if (c == upd_pkg::CH_PERCENT) r.phase = upd_pkg::PH_PERCENT;
			else r = put(r, c);
		end
		return r;
	endfunction

	function automatic work_t feed_pct(input work_t w, input logic [1:0] md,
			input logic [7:0] c);
		work_t      r;
		logic [4:0] cv;
		r = w;
		cv = hex_val(c);
		if (md == upd_pkg::MODE_LENIENT) begin
			if (cv[4]) begin
				r.held = c;
				r.phase = upd_pkg::PH_HELD;
			end else begin
				r.phase = upd_pkg::PH_NONE;
				r = put(r, upd_pkg::CH_PERCENT);
				r = feed_base(r, c);
			end
		end else if (md == upd_pkg::MODE_DISCARD) begin
			r.held = c;
			r.phase = upd_pkg::PH_HELD;
		end else if (cv[4]) begin
			r.held = c;
			r.phase = upd_pkg::PH_HELD;
		end else begin
			r.err = 1'b1;
			r.phase = upd_pkg::PH_NONE;
		end
		return r;
	endfunction

	function automatic work_t feed(input work_t w, input logic [1:0] md,
			input logic [7:0] c);
		work_t      r;
		logic [7:0] h;
		logic [4:0] hv;
		logic [4:0] cv;
		r = w;
		h = w.held;
		hv = hex_val(h);
		cv = hex_val(c);
		if (!r.err) begin
			if (r.phase == upd_pkg::PH_PERCENT) begin
				r = feed_pct(r, md, c);
			end else if (r.phase == upd_pkg::PH_HELD) begin
				r.phase = upd_pkg::PH_NONE;
				if (hv[4] && cv[4]) begin
					r = put(r, {hv[3:0], cv[3:0]});
				end else if (md == upd_pkg::MODE_LENIENT) begin
					// The held character is replayed first; it may open a new escape.
					r = put(r, upd_pkg::CH_PERCENT);
					r = feed_base(r, h);
					if (r.phase == upd_pkg::PH_PERCENT) r = feed_pct(r, md, c);
					else r = feed_base(r, c);
				end else if (md != upd_pkg::MODE_DISCARD) begin
					r.err = 1'b1;
				end
			end else begin
				r = feed_base(r, c);
			end
		end
		return r;
	endfunction

	function automatic work_t flush_once(input work_t w, input logic [1:0] md);
		work_t r;
		r = w;
		if (r.phase != upd_pkg::PH_NONE && !r.err) begin
			if (md != upd_pkg::MODE_LENIENT && md != upd_pkg::MODE_DISCARD) begin
				r.err = 1'b1;
				r.phase = upd_pkg::PH_NONE;
			end else if (r.phase == upd_pkg::PH_PERCENT) begin
				r.phase = upd_pkg::PH_NONE;
				if (md == upd_pkg::MODE_LENIENT) r = put(r, upd_pkg::CH_PERCENT);
			end else begin
				r.phase = upd_pkg::PH_NONE;
				if (md == upd_pkg::MODE_LENIENT) r = put(r, upd_pkg::CH_PERCENT);
				r = feed_base(r, r.held);
			end
		end
		return r;
	endfunction

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		w_in       = '0;
		w_in.phase = (phase_q == 2'd3) ? upd_pkg::PH_NONE : phase_q;
		w_in.held  = held_q;
		w_in.err   = err_q;
		w_fed      = feed(w_in, mode, in_byte);
		// A replayed held '%' can reopen an escape once, so two passes settle the end.
		w_done     = in_last ? flush_once(flush_once(w_fed, mode), mode) : w_fed;
	end

	always_comb begin
		push_data       = '0;
		push_data.bytes = w_done.b;
		push_data.last  = in_last;
		push_data.err   = in_last && w_done.err;
		push_data.bare  = (w_done.cnt == 2'd0);
		push_data.nres  = (w_done.cnt == 2'd0) ? 2'd1 : w_done.cnt;
		push            = accept && (in_last || w_done.cnt != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upd_pkg::PH_NONE;
			held_q  <= 8'd0;
			err_q   <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				phase_q <= upd_pkg::PH_NONE;
				held_q  <= 8'd0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= w_fed.phase;
				held_q  <= w_fed.held;
				err_q   <= w_fed.err;
			end
		end
	end

endmodule

// ----- rtl/upd_queue.sv -----
module upd_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  upd_pkg::bundle_t   push_data,
	input  logic               pop,
	output upd_pkg::bundle_t   head,
	output upd_pkg::q_status_t status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	upd_pkg::bundle_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ----- rtl/upd_back.sv -----
module upd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  upd_pkg::bundle_t   head,
	input  upd_pkg::q_status_t q_status,
	output logic               pop,
	output logic               out_tvalid,
	input  logic               out_tready,
	output logic [7:0]         out_tdata,
	output logic [1:0]         out_tuser,
	output logic               out_tlast
);

	logic [1:0] idx_q;
	logic       fin;
	logic       xfer;

	assign out_tvalid = !q_status.empty;
	assign xfer       = out_tvalid && out_tready;
	assign fin        = (idx_q == head.nres - 2'd1);
	assign pop        = xfer && fin;

	always_comb begin
		out_tdata    = head.bare ? 8'd0 : head.bytes[idx_q];
		out_tlast    = head.last && fin;
		out_tuser[0] = !head.bare;
		out_tuser[1] = head.err && out_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (xfer) begin
			idx_q <= fin ? 2'd0 : idx_q + 2'd1;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_tvalid |-> (idx_q < head.nres))
		else $error("result index beyond entry count");

	a_bare_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_tvalid && !out_tuser[0]) |-> out_tlast)
		else $error("bare end marker not marked last");

	a_idx_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_tvalid && !out_tready) |=> (idx_q == $past(idx_q)))
		else $error("result index moved while stalled");

	a_err_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_tvalid && out_tuser[1]) |-> (out_tlast && !out_tuser[0] == head.bare))
		else $error("error flag on a result that is not last");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_CHARS = 150;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
		logic       err;
	} result_t;

	typedef struct packed {
		logic       cfg;
		logic [1:0] mode;
		logic [7:0] ch;
		logic       last;
		logic       typed;
		result_t    want;
	} drow_t;

	localparam result_t NO_RES = '0;
	localparam int N_ROWS = 30;

	// Rows with typed set carry the one result their character must produce;
	// all others are checked against the decoder model below.
	localparam drow_t DIRECTED_ROWS [N_ROWS] = '{
		'{1'b0, upd_pkg::MODE_STRICT, "a", 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_STRICT, upd_pkg::CH_PLUS, 1'b0, 1'b1,
			'{upd_pkg::CH_SPACE, 1'b1, 1'b0, 1'b0}},
		'{1'b0, upd_pkg::MODE_STRICT, upd_pkg::CH_PERCENT, 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_STRICT, "4", 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_STRICT, "1", 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_STRICT, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
		'{1'b0, upd_pkg::MODE_STRICT, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
		'{1'b0, upd_pkg::MODE_STRICT, upd_pkg::CH_PERCENT, 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_STRICT, "z", 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_STRICT, "q", 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_STRICT, upd_pkg::CH_PERCENT, 1'b1, 1'b1,
			'{8'h00, 1'b0, 1'b1, 1'b1}},
		'{1'b1, upd_pkg::MODE_LENIENT, 8'h00, 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_LENIENT, upd_pkg::CH_PERCENT, 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_LENIENT, "g", 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_LENIENT, upd_pkg::CH_PERCENT, 1'b1, 1'b1,
			'{upd_pkg::CH_PERCENT, 1'b1, 1'b1, 1'b0}},
		'{1'b1, upd_pkg::MODE_DISCARD, 8'h00, 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_DISCARD, upd_pkg::CH_PERCENT, 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_DISCARD, "x", 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_DISCARD, "y", 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_DISCARD, upd_pkg::CH_PERCENT, 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_DISCARD, "a", 1'b1, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_DISCARD, upd_pkg::CH_PERCENT, 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_DISCARD, "g", 1'b0, 1'b0, NO_RES},
		'{1'b1, upd_pkg::MODE_LENIENT, 8'h00, 1'b0, 1'b0, NO_RES},
		'{1'b0, upd_pkg::MODE_LENIENT, "1", 1'b1, 1'b0, NO_RES},
		'{1'b1, MODE_UNUSED, 8'h00, 1'b0, 1'b0, NO_RES},
		'{1'b0, MODE_UNUSED, upd_pkg::CH_PERCENT, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
		'{1'b0, MODE_UNUSED, upd_pkg::CH_PERCENT, 1'b0, 1'b0, NO_RES},
		'{1'b0, MODE_UNUSED, "7", 1'b0, 1'b0, NO_RES},
		'{1'b0, MODE_UNUSED, "E", 1'b1, 1'b0, NO_RES}
	};

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_data = '0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = '0;  // [7:0] in_byte
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;       // [7:0] out_byte
	logic [1:0] m_axis_tuser;       // [0] out_valid, [1] decode_error
	logic       m_axis_tlast;

	url_percent_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Decoder model state.
	logic [1:0] pm_mode = upd_pkg::MODE_STRICT;
	logic [1:0] pm_phase = upd_pkg::PH_NONE;
	logic [7:0] pm_held = '0;
	logic       pm_err = 1'b0;
	logic [7:0] decoded[$];
	result_t    expected_q[$];

	int  mismatches = 0;
	int  results_checked = 0;
	int  chars_sent = 0;
	int  strings_sent = 0;
	int  mode_writes = 0;
	int  cycle_count = 0;
	int  sink_hold = 0;
	bit  steady = 1'b0;

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	function automatic void put_decoded(input logic [7:0] b);
		if (decoded.size() < upd_pkg::MAX_RES) decoded.insert(decoded.size(), b);
	endfunction

	function automatic void add_expected(input result_t r);
		expected_q.insert(expected_q.size(), r);
	endfunction

	// Characters that a failed escape hands back for normal decoding go to the
	// front of the work list, which keeps them in string order.
	function automatic void decode_chars(input logic [7:0] first);
		logic [7:0] work[$];
		logic [7:0] c;
		logic [7:0] h;
		int cv;
		int hv;
		work.push_front(first);
		while (work.size() > 0) begin
			c = work.pop_front();
			if (pm_err) continue;
			cv = hex_nibble(c);
			if (pm_phase == upd_pkg::PH_PERCENT) begin
				if (pm_mode == upd_pkg::MODE_LENIENT) begin
					if (cv >= 0) begin
						pm_held = c;
						pm_phase = upd_pkg::PH_HELD;
					end else begin
						pm_phase = upd_pkg::PH_NONE;
						put_decoded(upd_pkg::CH_PERCENT);
						work.push_front(c);
					end
				end else if (pm_mode == upd_pkg::MODE_DISCARD || cv >= 0) begin
					pm_held = c;
					pm_phase = upd_pkg::PH_HELD;
				end else begin
					pm_err = 1'b1;
					pm_phase = upd_pkg::PH_NONE;
				end
			end else if (pm_phase == upd_pkg::PH_HELD) begin
				h = pm_held;
				hv = hex_nibble(h);
				pm_phase = upd_pkg::PH_NONE;
				if (hv >= 0 && cv >= 0) begin
					put_decoded(8'(hv * 16 + cv));
				end else if (pm_mode == upd_pkg::MODE_LENIENT) begin
					put_decoded(upd_pkg::CH_PERCENT);
					work.push_front(c);
					work.push_front(h);
				end else if (pm_mode != upd_pkg::MODE_DISCARD) begin
					pm_err = 1'b1;
				end
			end else begin
				pm_phase = upd_pkg::PH_NONE;
				if (c == upd_pkg::CH_PLUS) put_decoded(upd_pkg::CH_SPACE);
				else if (c == upd_pkg::CH_PERCENT) pm_phase = upd_pkg::PH_PERCENT;
				else put_decoded(c);
			end
		end
	endfunction

	function automatic void predict_char(input logic [7:0] ch, input logic last);
		decoded.delete();
		decode_chars(ch);
		if (!last) begin
			foreach (decoded[k]) add_expected('{decoded[k], 1'b1, 1'b0, 1'b0});
			return;
		end
		// Resolve an escape left open at the end of the string.
		while (pm_phase != upd_pkg::PH_NONE && !pm_err) begin
			if (pm_mode != upd_pkg::MODE_LENIENT && pm_mode != upd_pkg::MODE_DISCARD) begin
				pm_err = 1'b1;
				pm_phase = upd_pkg::PH_NONE;
			end else if (pm_phase == upd_pkg::PH_PERCENT) begin
				pm_phase = upd_pkg::PH_NONE;
				if (pm_mode == upd_pkg::MODE_LENIENT) put_decoded(upd_pkg::CH_PERCENT);
			end else begin
				pm_phase = upd_pkg::PH_NONE;
				if (pm_mode == upd_pkg::MODE_LENIENT) put_decoded(upd_pkg::CH_PERCENT);
				decode_chars(pm_held);
			end
		end
		if (decoded.size() == 0) begin
			add_expected('{8'h00, 1'b0, 1'b1, pm_err});
		end else begin
			foreach (decoded[k]) begin
				add_expected('{decoded[k], 1'b1, k == decoded.size() - 1,
					k == decoded.size() - 1 && pm_err});
			end
		end
		pm_phase = upd_pkg::PH_NONE;
		pm_held = '0;
		pm_err = 1'b0;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] random_hex();
		int v;
		v = $urandom_range(0, 21);
		if (v < 10) return 8'("0" + v);
		if (v < 16) return 8'("a" + v - 10);
		return 8'("A" + v - 16);
	endfunction

	// Called at a clock edge; leaves tvalid high at the edge the character is taken.
	task automatic send_char(input logic [7:0] ch, input logic last, input logic typed,
		input result_t want);
		int gap;
		int mark;
		gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		mark = expected_q.size();
		predict_char(ch, last);
		if (typed) begin
			while (expected_q.size() > mark) void'(expected_q.pop_back());
			add_expected(want);
		end
		chars_sent++;
	endtask

	// The mode is only written once the block has handed out every pending result.
	task automatic write_mode(input logic [1:0] m);
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pm_mode = m;
		mode_writes++;
	endtask

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			m_axis_tready <= 1'b0;
			sink_hold--;
		end else begin
			m_axis_tready <= 1'b1;
			if (!steady && $urandom_range(0, 3) == 0) sink_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result byte=%h valid=%b last=%b err=%b", $time,
					got.data, got.valid, got.last, got.err);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				results_checked++;
				if (got.data != want.data || got.valid != want.valid ||
					got.last != want.last || got.err != want.err) begin
					$display("%0t: expected byte=%h valid=%b last=%b err=%b,",
						$time, want.data, want.valid, want.last, want.err,
						" got byte=%h valid=%b last=%b err=%b",
						got.data, got.valid, got.last, got.err);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
				expected_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [7:0] text[$];
		int random_target;
		int r;
		int nstr;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			if (DIRECTED_ROWS[i].cfg) begin
				write_mode(DIRECTED_ROWS[i].mode);
			end else begin
				send_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
					DIRECTED_ROWS[i].want);
				if (DIRECTED_ROWS[i].last) strings_sent++;
			end
		end

		// Random strings: well-formed escapes, plus signs and raw bytes, with some broken ones mixed in.
		random_target = chars_sent + RANDOM_CHARS;
		while (chars_sent < random_target) begin
			write_mode(2'($urandom_range(0, 3)));
			steady = ($urandom_range(0, 3) == 0);
			nstr = $urandom_range(3, 6);
			repeat (nstr) begin
				text.delete();
				repeat ($urandom_range(1, 4)) begin
					r = $urandom_range(0, 99);
					if (r < 40) begin
						text.insert(text.size(), upd_pkg::CH_PERCENT);
						text.insert(text.size(), random_hex());
						text.insert(text.size(), random_hex());
					end else if (r < 50) begin
						text.insert(text.size(), upd_pkg::CH_PLUS);
					end else if (r < 75) begin
						text.insert(text.size(), 8'($urandom_range(0, 255)));
					end else if (r < 90) begin
						text.insert(text.size(), upd_pkg::CH_PERCENT);
						text.insert(text.size(), 8'($urandom_range(0, 255)));
						text.insert(text.size(), ($urandom_range(0, 1) == 0) ? random_hex() :
							8'($urandom_range(0, 255)));
					end else begin
						text.insert(text.size(), upd_pkg::CH_PERCENT);
					end
				end
				foreach (text[k]) send_char(text[k], k == text.size() - 1, 1'b0, NO_RES);
				strings_sent++;
			end
		end

		s_axis_tvalid <= 1'b0;
		steady = 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Decoded %0d strings (%0d characters) under %0d mode writes covering all four",
			strings_sent, chars_sent, mode_writes);
		$display("mode values; %0d results compared, %0d mismatching.", results_checked,
			mismatches);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder.sv
tb/testbench.sv
